// ===== src/rgd_pkg.sv =====
// Shared types and constants of the random gust and direction generator.
package rgd_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam logic [31:0] LCG_MUL   = 32'd1664525;
  localparam logic [31:0] LCG_INC   = 32'd1013904223;
  localparam logic [31:0] RNG_SEED  = 32'd54321;
  localparam int          FRAC_SHIFT = 24;

  typedef enum logic [1:0] {
    SU_MUL,
    SU_DIV,
    SU_SQRT
  } su_op_e;

  typedef struct packed {
    logic   start;
    su_op_e op;
  } su_req_t;

  typedef enum logic [2:0] {
    DRW_GT,
    DRW_GD,
    DRW_GR,
    DRW_SEL,
    DRW_DX,
    DRW_DY,
    DRW_DZ,
    DRW_DD
  } drw_e;

  typedef enum logic [1:0] {
    CLS_BIG,
    CLS_MED,
    CLS_SMALL
  } cls_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_GCHK,
    ST_LCG,
    ST_LCG_W,
    ST_SPAN,
    ST_SPAN_W,
    ST_LMUL,
    ST_LMUL_W,
    ST_DCHK,
    ST_SQ,
    ST_SQ_W,
    ST_ROOT,
    ST_ROOT_W,
    ST_DS,
    ST_DS_W,
    ST_MV,
    ST_MV_W,
    ST_DIV,
    ST_DIV_W,
    ST_DONE
  } st_e;

endpackage

// ===== src/random_gust_and_direction_generator.sv =====
// Top level: gust timer, gust ramp, direction timer and direction offset sequencer.
// A tick runs on the serial unit the gust ramp multiply, three squares, the root, the offset
//   step and, unless the offset snaps, a multiply-divide per component, plus the random
//   draws and selector draw on a timer expiry; with gusts off it goes straight to output.
// Throughput: one word at a time; the single bit-serial multiply/divide/root unit sets it.
// Reset: asynchronous, active low; LCG seeded to 54321, gusts on, class small, control zero.
module random_gust_and_direction_generator #(
  parameter int FRAC_BITS = rgd_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [15:0]                 time_step_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [FRAC_BITS:0]          gust_level_o,
  output logic signed [FRAC_BITS+1:0] offset_x_o,
  output logic signed [FRAC_BITS+1:0] offset_y_o,
  output logic signed [FRAC_BITS+1:0] offset_z_o
);

  // Field widths, all derived from the fraction width.
  localparam int LVW = FRAC_BITS + 1;   // level
  localparam int OFW = FRAC_BITS + 2;   // offset component
  localparam int TW  = FRAC_BITS + 3;   // timers and ramp rate
  localparam int VW  = FRAC_BITS + 4;   // signed draw result
  localparam int DW  = FRAC_BITS + 3;   // offset difference
  localparam int LW  = FRAC_BITS + 3;   // vector length
  localparam int MW  = FRAC_BITS + 30 + (FRAC_BITS % 2);

  // Fixed-point constants, rounded half up.
  localparam int ONE_Q  = 1 << FRAC_BITS;
  localparam int Q3_10  = ((3 << FRAC_BITS) + 5) / 10;
  localparam int Q1_2   = ((1 << FRAC_BITS) + 1) / 2;
  localparam int Q3_2   = ((3 << FRAC_BITS) + 1) / 2;
  localparam int Q4_5   = ((4 << FRAC_BITS) + 2) / 5;
  localparam int Q2_5   = ((2 << FRAC_BITS) + 2) / 5;
  localparam int Q3_20  = ((3 << FRAC_BITS) + 10) / 20;
  localparam int Q1_10  = ((1 << FRAC_BITS) + 5) / 10;
  localparam int Q1_5   = ((1 << FRAC_BITS) + 2) / 5;
  localparam int Q1_20  = ((1 << FRAC_BITS) + 10) / 20;
  // Selector threshold for the big class: f * 20 < 3 * 2^24.
  localparam logic [28:0] BIG_LIM = 29'd50331648;

  rgd_pkg::st_e  state_q, state_d;
  logic          en_q, en_d;
  logic [15:0]   dt_q, dt_d;
  logic [31:0]   rng_q, rng_d;
  logic [LVW-1:0] lvl_q, lvl_d;
  logic [LVW-1:0] goal_q, goal_d;
  logic [TW-1:0] gcnt_q, gcnt_d;
  logic [TW-1:0] ramp_q, ramp_d;
  logic [TW-1:0] dcnt_q, dcnt_d;
  logic signed [OFW-1:0] dgoal_q [3];
  logic signed [OFW-1:0] dgoal_d [3];
  logic signed [OFW-1:0] dnow_q [3];
  logic signed [OFW-1:0] dnow_d [3];
  logic          calm_q, calm_d;
  rgd_pkg::cls_e cls_q, cls_d;
  rgd_pkg::drw_e drw_q, drw_d;
  logic [1:0]    idx_q, idx_d;
  logic [MW-1:0] sq_q, sq_d;
  logic [LW-1:0] len_q, len_d;
  logic [15:0]   dstep_q, dstep_d;
  logic          out_valid_q, out_valid_d;
  logic          out_load;

  // Serial unit hookup.
  rgd_pkg::su_req_t su_req;
  logic [MW-1:0]    su_a, su_b;
  logic             su_done;
  logic [MW-1:0]    su_res;

  // Decoded conditions.
  logic                  g_expire, d_expire, calm_next;
  logic signed [VW-1:0]  draw_lo;
  logic [VW-2:0]         draw_span;
  logic signed [VW-1:0]  draw_val;
  logic [23:0]           frac;
  logic [28:0]           frac_x20;
  logic signed [DW-1:0]  d_cur;
  logic                  d_neg;
  logic [DW-1:0]         m_cur;
  logic signed [LVW:0]   lvl_diff;
  logic [LVW-1:0]        lvl_adiff;
  logic [19:0]           lvl_step;
  logic [15:0]           ds_val;
  logic                  dir_snap;
  logic [OFW-1:0]        mv;

  rgd_serial_unit #(
    .MW (MW)
  ) u_su (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (su_req),
    .a_i    (su_a),
    .b_i    (su_b),
    .done_o (su_done),
    .res_o  (su_res)
  );

  assign in_stall_o  = (state_q != rgd_pkg::ST_IDLE);
  assign cfg_ready_o = (state_q == rgd_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  assign g_expire  = 32'(dt_q) >= 32'(gcnt_q);
  assign d_expire  = 32'(dt_q) >= 32'(dcnt_q);
  assign calm_next = 32'(goal_q) >= 32'(Q3_10);
  assign frac      = rng_q[23:0];
  assign frac_x20  = {1'b0, frac, 4'b0} + {3'b0, frac, 2'b0};

  // Goal minus current offset for the indexed component, and its magnitude.
  assign d_cur = $signed({dgoal_q[idx_q][OFW-1], dgoal_q[idx_q]})
               - $signed({dnow_q[idx_q][OFW-1], dnow_q[idx_q]});
  assign d_neg = d_cur[DW-1];
  assign m_cur = d_neg ? DW'(-d_cur) : DW'(d_cur);

  // Level ramp terms; the step is the product from the serial unit.
  assign lvl_diff  = $signed({1'b0, goal_q}) - $signed({1'b0, lvl_q});
  assign lvl_adiff = lvl_diff[LVW] ? LVW'(-lvl_diff) : LVW'(lvl_diff);
  assign lvl_step  = su_res[FRAC_BITS +: 20];

  assign ds_val   = su_res[FRAC_BITS +: 16];
  assign dir_snap = (len_q == '0) || (32'(len_q) <= 32'(ds_val));
  assign mv       = OFW'(su_res[LW-1:0]);

  assign draw_val = draw_lo + $signed({1'b0, su_res[rgd_pkg::FRAC_SHIFT +: VW-1]});

  // Range of the draw in progress.
  always_comb begin
    draw_lo   = '0;
    draw_span = '0;
    case (drw_q)
      rgd_pkg::DRW_GT: begin
        draw_lo   = VW'(Q1_2);
        draw_span = (VW-1)'(ONE_Q - Q1_2);
      end
      rgd_pkg::DRW_GD: begin
        draw_lo   = calm_q ? VW'(3 * ONE_Q) : VW'(Q3_2);
        draw_span = calm_q ? (VW-1)'(4 * ONE_Q) : (VW-1)'(4 * ONE_Q - Q3_2);
      end
      rgd_pkg::DRW_GR: begin
        draw_lo   = calm_q ? VW'(3 * ONE_Q) : VW'(Q3_2);
        draw_span = calm_q ? (VW-1)'(3 * ONE_Q) : (VW-1)'(4 * ONE_Q - Q3_2);
      end
      rgd_pkg::DRW_DX: begin
        case (cls_q)
          rgd_pkg::CLS_BIG: begin
            draw_lo = VW'(-Q4_5); draw_span = (VW-1)'(2 * Q4_5);
          end
          rgd_pkg::CLS_MED: begin
            draw_lo = VW'(-Q2_5); draw_span = (VW-1)'(2 * Q2_5);
          end
          default: begin
            draw_lo = VW'(-Q3_20); draw_span = (VW-1)'(2 * Q3_20);
          end
        endcase
      end
      rgd_pkg::DRW_DY: begin
        case (cls_q)
          rgd_pkg::CLS_BIG: begin
            draw_lo = VW'(-Q3_10); draw_span = (VW-1)'(2 * Q3_10);
          end
          rgd_pkg::CLS_MED: begin
            draw_lo = VW'(-Q3_20); draw_span = (VW-1)'(2 * Q3_20);
          end
          default: begin
            draw_lo = VW'(-Q1_20); draw_span = (VW-1)'(2 * Q1_20);
          end
        endcase
      end
      rgd_pkg::DRW_DZ: begin
        if (cls_q == rgd_pkg::CLS_BIG) begin
          draw_lo = VW'(-Q1_2); draw_span = (VW-1)'(Q1_2 + Q2_5);
        end else begin
          draw_lo = VW'(-Q1_10); draw_span = (VW-1)'(Q1_10 + Q1_5);
        end
      end
      rgd_pkg::DRW_DD: begin
        draw_lo   = VW'(ONE_Q);
        draw_span = (VW-1)'(4 * ONE_Q);
      end
      default: ;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      rgd_pkg::ST_IDLE:
        if (in_valid_i) state_d = en_q ? rgd_pkg::ST_GCHK : rgd_pkg::ST_DONE;
      rgd_pkg::ST_GCHK:
        state_d = g_expire ? rgd_pkg::ST_LCG : rgd_pkg::ST_LMUL;
      rgd_pkg::ST_LCG:   state_d = rgd_pkg::ST_LCG_W;
      rgd_pkg::ST_LCG_W: if (su_done) state_d = rgd_pkg::ST_SPAN;
      rgd_pkg::ST_SPAN:
        state_d = (drw_q == rgd_pkg::DRW_SEL) ? rgd_pkg::ST_LCG : rgd_pkg::ST_SPAN_W;
      rgd_pkg::ST_SPAN_W:
        if (su_done) begin
          if (drw_q == rgd_pkg::DRW_GR)      state_d = rgd_pkg::ST_LMUL;
          else if (drw_q == rgd_pkg::DRW_DD) state_d = rgd_pkg::ST_SQ;
          else                               state_d = rgd_pkg::ST_LCG;
        end
      rgd_pkg::ST_LMUL:   state_d = rgd_pkg::ST_LMUL_W;
      rgd_pkg::ST_LMUL_W: if (su_done) state_d = rgd_pkg::ST_DCHK;
      rgd_pkg::ST_DCHK:
        state_d = d_expire ? rgd_pkg::ST_LCG : rgd_pkg::ST_SQ;
      rgd_pkg::ST_SQ:     state_d = rgd_pkg::ST_SQ_W;
      rgd_pkg::ST_SQ_W:
        if (su_done) state_d = (idx_q == 2'd2) ? rgd_pkg::ST_ROOT : rgd_pkg::ST_SQ;
      rgd_pkg::ST_ROOT:   state_d = rgd_pkg::ST_ROOT_W;
      rgd_pkg::ST_ROOT_W: if (su_done) state_d = rgd_pkg::ST_DS;
      rgd_pkg::ST_DS:     state_d = rgd_pkg::ST_DS_W;
      rgd_pkg::ST_DS_W:
        if (su_done) state_d = dir_snap ? rgd_pkg::ST_DONE : rgd_pkg::ST_MV;
      rgd_pkg::ST_MV:     state_d = rgd_pkg::ST_MV_W;
      rgd_pkg::ST_MV_W:   if (su_done) state_d = rgd_pkg::ST_DIV;
      rgd_pkg::ST_DIV:    state_d = rgd_pkg::ST_DIV_W;
      rgd_pkg::ST_DIV_W:
        if (su_done) state_d = (idx_q == 2'd2) ? rgd_pkg::ST_DONE : rgd_pkg::ST_MV;
      rgd_pkg::ST_DONE:
        if (!out_valid_q || !out_stall_i) state_d = rgd_pkg::ST_IDLE;
      default: state_d = rgd_pkg::ST_IDLE;
    endcase
  end

  // Datapath updates and serial unit requests.
  always_comb begin
    en_d        = en_q;
    dt_d        = dt_q;
    rng_d       = rng_q;
    lvl_d       = lvl_q;
    goal_d      = goal_q;
    gcnt_d      = gcnt_q;
    ramp_d      = ramp_q;
    dcnt_d      = dcnt_q;
    dgoal_d     = dgoal_q;
    dnow_d      = dnow_q;
    calm_d      = calm_q;
    cls_d       = cls_q;
    drw_d       = drw_q;
    idx_d       = idx_q;
    sq_d        = sq_q;
    len_d       = len_q;
    dstep_d     = dstep_q;
    out_load    = 1'b0;
    su_req      = '{start: 1'b0, op: rgd_pkg::SU_MUL};
    su_a        = '0;
    su_b        = '0;

    if (cfg_valid_i && cfg_ready_o) en_d = cfg_wdata_i;

    case (state_q)
      rgd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          dt_d  = time_step_i;
          idx_d = '0;
          if (!en_q) lvl_d = LVW'(ONE_Q);
        end
      end
      rgd_pkg::ST_GCHK: begin
        // Expiry: calm if a gust is on, else start a gust; drop any residue.
        if (g_expire) begin
          calm_d = calm_next;
          if (calm_next) begin
            goal_d = '0;
            drw_d  = rgd_pkg::DRW_GD;
          end else begin
            drw_d  = rgd_pkg::DRW_GT;
          end
        end else begin
          gcnt_d = gcnt_q - TW'(dt_q);
        end
      end
      rgd_pkg::ST_LCG: begin
        su_req = '{start: 1'b1, op: rgd_pkg::SU_MUL};
        su_a   = MW'(rng_q);
        su_b   = MW'(rgd_pkg::LCG_MUL);
      end
      rgd_pkg::ST_LCG_W: begin
        if (su_done) rng_d = su_res[31:0] + rgd_pkg::LCG_INC;
      end
      rgd_pkg::ST_SPAN: begin
        if (drw_q == rgd_pkg::DRW_SEL) begin
          // Selector picks the class from the raw fraction.
          if (frac_x20 < BIG_LIM)  cls_d = rgd_pkg::CLS_BIG;
          else if (!frac[23])      cls_d = rgd_pkg::CLS_MED;
          else                     cls_d = rgd_pkg::CLS_SMALL;
          drw_d = rgd_pkg::DRW_DX;
        end else begin
          su_req = '{start: 1'b1, op: rgd_pkg::SU_MUL};
          su_a   = MW'(frac);
          su_b   = MW'(draw_span);
        end
      end
      rgd_pkg::ST_SPAN_W: begin
        if (su_done) begin
          case (drw_q)
            rgd_pkg::DRW_GT: begin
              goal_d = LVW'(draw_val);
              drw_d  = rgd_pkg::DRW_GD;
            end
            rgd_pkg::DRW_GD: begin
              gcnt_d = TW'(draw_val);
              drw_d  = rgd_pkg::DRW_GR;
            end
            rgd_pkg::DRW_GR: ramp_d = TW'(draw_val);
            rgd_pkg::DRW_DX: begin
              dgoal_d[0] = OFW'(draw_val);
              drw_d      = rgd_pkg::DRW_DY;
            end
            rgd_pkg::DRW_DY: begin
              dgoal_d[1] = OFW'(draw_val);
              if (cls_q == rgd_pkg::CLS_SMALL) begin
                dgoal_d[2] = '0;
                drw_d      = rgd_pkg::DRW_DD;
              end else begin
                drw_d      = rgd_pkg::DRW_DZ;
              end
            end
            rgd_pkg::DRW_DZ: begin
              dgoal_d[2] = OFW'(draw_val);
              drw_d      = rgd_pkg::DRW_DD;
            end
            rgd_pkg::DRW_DD: dcnt_d = TW'(draw_val);
            default: ;
          endcase
        end
      end
      rgd_pkg::ST_LMUL: begin
        su_req = '{start: 1'b1, op: rgd_pkg::SU_MUL};
        su_a   = MW'(ramp_q);
        su_b   = MW'(dt_q);
      end
      rgd_pkg::ST_LMUL_W: begin
        if (su_done) begin
          if (32'(lvl_adiff) < 32'(lvl_step))  lvl_d = goal_q;
          else if (!lvl_diff[LVW] && lvl_diff != '0)
            lvl_d = LVW'(32'(lvl_q) + 32'(lvl_step));
          else if (lvl_diff[LVW])
            lvl_d = LVW'(32'(lvl_q) - 32'(lvl_step));
        end
      end
      rgd_pkg::ST_DCHK: begin
        if (d_expire) drw_d  = rgd_pkg::DRW_SEL;
        else          dcnt_d = dcnt_q - TW'(dt_q);
      end
      rgd_pkg::ST_SQ: begin
        su_req = '{start: 1'b1, op: rgd_pkg::SU_MUL};
        su_a   = MW'(m_cur);
        su_b   = MW'(m_cur);
      end
      rgd_pkg::ST_SQ_W: begin
        if (su_done) begin
          sq_d  = ((idx_q == '0) ? '0 : sq_q) + su_res;
          idx_d = (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
        end
      end
      rgd_pkg::ST_ROOT: begin
        su_req = '{start: 1'b1, op: rgd_pkg::SU_SQRT};
        su_a   = sq_q;
      end
      rgd_pkg::ST_ROOT_W: begin
        if (su_done) len_d = su_res[LW-1:0];
      end
      rgd_pkg::ST_DS: begin
        su_req = '{start: 1'b1, op: rgd_pkg::SU_MUL};
        su_a   = MW'(Q4_5);
        su_b   = MW'(dt_q);
      end
      rgd_pkg::ST_DS_W: begin
        if (su_done) begin
          dstep_d = ds_val;
          if (dir_snap) dnow_d = dgoal_q;
        end
      end
      rgd_pkg::ST_MV: begin
        su_req = '{start: 1'b1, op: rgd_pkg::SU_MUL};
        su_a   = MW'(m_cur);
        su_b   = MW'(dstep_q);
      end
      rgd_pkg::ST_DIV: begin
        // Product still sits in the unit's accumulator.
        su_req = '{start: 1'b1, op: rgd_pkg::SU_DIV};
        su_a   = su_res;
        su_b   = MW'(len_q);
      end
      rgd_pkg::ST_DIV_W: begin
        if (su_done) begin
          dnow_d[idx_q] = d_neg ? dnow_q[idx_q] - $signed(mv)
                                : dnow_q[idx_q] + $signed(mv);
          idx_d = (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
        end
      end
      rgd_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) out_load = 1'b1;
      end
      default: ;
    endcase

    out_valid_d = out_load | (out_valid_q & out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rgd_pkg::ST_IDLE;
      en_q        <= 1'b1;
      rng_q       <= rgd_pkg::RNG_SEED;
      lvl_q       <= '0;
      goal_q      <= '0;
      gcnt_q      <= '0;
      ramp_q      <= '0;
      dcnt_q      <= '0;
      dgoal_q     <= '{default: '0};
      dnow_q      <= '{default: '0};
      calm_q      <= 1'b0;
      cls_q       <= rgd_pkg::CLS_SMALL;
      drw_q       <= rgd_pkg::DRW_GT;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      en_q        <= en_d;
      rng_q       <= rng_d;
      lvl_q       <= lvl_d;
      goal_q      <= goal_d;
      gcnt_q      <= gcnt_d;
      ramp_q      <= ramp_d;
      dcnt_q      <= dcnt_d;
      dgoal_q     <= dgoal_d;
      dnow_q      <= dnow_d;
      calm_q      <= calm_d;
      cls_q       <= cls_d;
      drw_q       <= drw_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk_i) begin
    dt_q    <= dt_d;
    sq_q    <= sq_d;
    len_q   <= len_d;
    dstep_q <= dstep_d;
    if (out_load) begin
      gust_level_o <= lvl_q;
      offset_x_o   <= dnow_q[0];
      offset_y_o   <= dnow_q[1];
      offset_z_o   <= dnow_q[2];
    end
  end

endmodule

// ===== src/rgd_serial_unit.sv =====
// Bit-serial multiply, restoring divide and square root unit.
module rgd_serial_unit #(
  parameter int MW = 46
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rgd_pkg::su_req_t     req_i,
  input  logic [MW-1:0]        a_i,
  input  logic [MW-1:0]        b_i,
  output logic                 done_o,
  output logic [MW-1:0]        res_o
);

  localparam int CW = $clog2(MW + 1);

  logic             busy_q, busy_d;
  rgd_pkg::su_op_e  op_q, op_d;
  logic [MW-1:0]    acc_q, acc_d;
  logic [MW-1:0]    x_q, x_d;
  logic [MW-1:0]    y_q, y_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [MW:0]      div_rem;
  logic [MW+1:0]    sq_rem;
  logic [MW+1:0]    sq_trial;

  assign div_rem  = {acc_q, x_q[MW-1]};
  assign sq_rem   = {acc_q, x_q[MW-1:MW-2]};
  assign sq_trial = {y_q, 2'b01};

  always_comb begin
    busy_d = busy_q;
    op_d   = op_q;
    acc_d  = acc_q;
    x_d    = x_q;
    y_d    = y_q;
    cnt_d  = cnt_q;
    done_o = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      acc_d  = '0;
      x_d    = a_i;
      case (req_i.op)
        rgd_pkg::SU_MUL: begin
          y_d   = b_i;
          cnt_d = '0;
        end
        rgd_pkg::SU_DIV: begin
          y_d   = b_i;
          cnt_d = CW'(MW);
        end
        default: begin
          y_d   = '0;
          cnt_d = CW'(MW / 2);
        end
      endcase
    end else if (busy_q) begin
      case (op_q)
        rgd_pkg::SU_MUL: begin
          if (y_q == '0) begin
            done_o = 1'b1;
            busy_d = 1'b0;
          end else begin
            if (y_q[0]) acc_d = acc_q + x_q;
            x_d = {x_q[MW-2:0], 1'b0};
            y_d = {1'b0, y_q[MW-1:1]};
          end
        end
        rgd_pkg::SU_DIV: begin
          if (cnt_q == '0) begin
            done_o = 1'b1;
            busy_d = 1'b0;
          end else begin
            if (div_rem >= {1'b0, y_q}) begin
              acc_d = MW'(div_rem - {1'b0, y_q});
              x_d   = {x_q[MW-2:0], 1'b1};
            end else begin
              acc_d = div_rem[MW-1:0];
              x_d   = {x_q[MW-2:0], 1'b0};
            end
            cnt_d = cnt_q - 1'b1;
          end
        end
        default: begin
          if (cnt_q == '0) begin
            done_o = 1'b1;
            busy_d = 1'b0;
          end else begin
            if (sq_rem >= sq_trial) begin
              acc_d = MW'(sq_rem - sq_trial);
              y_d   = {y_q[MW-2:0], 1'b1};
            end else begin
              acc_d = sq_rem[MW-1:0];
              y_d   = {y_q[MW-2:0], 1'b0};
            end
            x_d   = {x_q[MW-3:0], 2'b00};
            cnt_d = cnt_q - 1'b1;
          end
        end
      endcase
    end
  end

  always_comb begin
    case (op_q)
      rgd_pkg::SU_MUL: res_o = acc_q;
      rgd_pkg::SU_DIV: res_o = x_q;
      default:         res_o = y_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      op_q   <= rgd_pkg::SU_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
  end

endmodule

// ===== src/rgd_checker.sv =====
// Port-level checker for the generator, bound to the top level.
module rgd_checker #(
  parameter int FRAC_BITS = rgd_pkg::FRAC_BITS_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [15:0]                 time_step_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [FRAC_BITS:0]          gust_level_o,
  input logic signed [FRAC_BITS+1:0] offset_x_o,
  input logic signed [FRAC_BITS+1:0] offset_y_o,
  input logic signed [FRAC_BITS+1:0] offset_z_o
);

  // One word in flight: an accepted word blocks the input next cycle.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while a word is in flight");

  // Level never exceeds full strength.
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> gust_level_o <= (FRAC_BITS+1)'(1 << FRAC_BITS))
    else $error("gust level above full strength");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(gust_level_o) && $stable(offset_x_o)
      && $stable(offset_y_o) && $stable(offset_z_o))
    else $error("stalled result changed");

  // Hold a stalled input word steady.
  a_in_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(time_step_i))
    else $error("stalled input word changed");

endmodule

bind random_gust_and_direction_generator rgd_checker #(.FRAC_BITS(FRAC_BITS)) u_rgd_checker (.*);

// ===== tb/random_gust_and_direction_generator_test.sv =====
// Testbench for the random gust and direction generator: table-driven and random ticks.
module random_gust_and_direction_generator_test;

  localparam int QB = rgd_pkg::FRAC_BITS_DEF;
  localparam longint ONE = longint'(1) << QB;
  localparam int SETTLE_CYCLES = 1500;  // longest tick with every draw, plus margin
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [QB:0]   level;
    logic [QB+1:0] ox;
    logic [QB+1:0] oy;
    logic [QB+1:0] oz;
  } wind_t;

  // One row of the directed table: enable setting, tick length, and where the
  // answer is obvious, the expected word.
  typedef struct {
    bit          en;
    logic [15:0] dt;
    bit          known;
    wind_t       want;
  } tick_row_t;

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o, cfg_wdata_i;
  logic in_valid_i, in_stall_o;
  logic [15:0] time_step_i;
  logic out_valid_o, out_stall_i;
  logic [QB:0] gust_level_o;
  logic signed [QB+1:0] offset_x_o, offset_y_o, offset_z_o;

  random_gust_and_direction_generator #(.FRAC_BITS(QB)) DUT (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .time_step_i,
    .out_valid_o, .out_stall_i, .gust_level_o, .offset_x_o, .offset_y_o, .offset_z_o
  );

  // Predicted block state
  bit                gusts_on;
  logic [31:0]       lcg;
  longint            lvl_now, lvl_goal, gust_cd, ramp, dir_cd;
  longint            goal_v[3], now_v[3];

  wind_t             wind_q[$];
  int                errors;
  int                gap_pct, stall_pct;
  int                quiet_cycles;

  function automatic longint fix(longint n, longint d);
    return ((n << QB) + d / 2) / d;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Advance the LCG and return its low 24 bits.
  function automatic longint unsigned next_frac();
    lcg = lcg * rgd_pkg::LCG_MUL + rgd_pkg::LCG_INC;
    return longint'(lcg[23:0]);
  endfunction

  function automatic longint draw_between(longint lo, longint hi);
    longint unsigned f;
    f = next_frac();
    return lo + longint'((f * longint'(hi - lo)) >> rgd_pkg::FRAC_SHIFT);
  endfunction

  function automatic void reset_wind();
    gusts_on = 1;
    lcg = rgd_pkg::RNG_SEED;
    lvl_now = 0; lvl_goal = 0; gust_cd = 0; ramp = 0; dir_cd = 0;
    for (int i = 0; i < 3; i++) begin
      goal_v[i] = 0;
      now_v[i] = 0;
    end
  endfunction

  // Advance the gust and direction machines by one tick and return the word.
  function automatic wind_t advance_wind(longint dt);
    longint diff, stp, ad, dv[3], mv;
    longint unsigned sq, len, dstep, sel, m;
    wind_t w;
    if (gusts_on) begin
      if (dt >= gust_cd) begin
        if (lvl_goal < fix(3, 10)) begin
          lvl_goal = draw_between(fix(1, 2), ONE);
          gust_cd = draw_between(fix(3, 2), fix(4, 1));
          ramp = draw_between(fix(3, 2), fix(4, 1));
        end else begin
          lvl_goal = 0;
          gust_cd = draw_between(fix(3, 1), fix(7, 1));
          ramp = draw_between(fix(3, 1), fix(6, 1));
        end
      end else begin
        gust_cd -= dt;
      end
      diff = lvl_goal - lvl_now;
      stp = (ramp * dt) >>> QB;
      ad = diff < 0 ? -diff : diff;
      if (ad < stp) lvl_now = lvl_goal;
      else lvl_now += diff > 0 ? stp : -stp;

      if (dt >= dir_cd) begin
        sel = next_frac();
        if (sel * 20 < (64'd3 << 24)) begin
          goal_v[0] = draw_between(-fix(4, 5), fix(4, 5));
          goal_v[1] = draw_between(-fix(3, 10), fix(3, 10));
          goal_v[2] = draw_between(-fix(1, 2), fix(2, 5));
        end else if (sel < (64'd1 << 23)) begin
          goal_v[0] = draw_between(-fix(2, 5), fix(2, 5));
          goal_v[1] = draw_between(-fix(3, 20), fix(3, 20));
          goal_v[2] = draw_between(-fix(1, 10), fix(1, 5));
        end else begin
          goal_v[0] = draw_between(-fix(3, 20), fix(3, 20));
          goal_v[1] = draw_between(-fix(1, 20), fix(1, 20));
          goal_v[2] = 0;
        end
        dir_cd = draw_between(fix(1, 1), fix(5, 1));
      end else begin
        dir_cd -= dt;
      end

      sq = 0;
      for (int i = 0; i < 3; i++) begin
        dv[i] = goal_v[i] - now_v[i];
        m = dv[i] < 0 ? -dv[i] : dv[i];
        sq += m * m;
      end
      len = int_sqrt(sq);
      dstep = (longint'(fix(4, 5)) * dt) >> QB;
      if (len == 0 || len <= dstep) begin
        for (int i = 0; i < 3; i++) now_v[i] = goal_v[i];
      end else begin
        for (int i = 0; i < 3; i++) begin
          m = dv[i] < 0 ? -dv[i] : dv[i];
          mv = longint'((m * dstep) / len);
          now_v[i] += dv[i] < 0 ? -mv : mv;
        end
      end
    end else begin
      lvl_now = ONE;
    end
    w.level = lvl_now[QB:0];
    w.ox = now_v[0][QB+1:0];
    w.oy = now_v[1][QB+1:0];
    w.oz = now_v[2][QB+1:0];
    return w;
  endfunction

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  // Drain: wait out every expected word, then give the block time to finish
  // any tick whose word has not yet been produced.
  task automatic drain_wind();
    while (wind_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_enable(bit v);
    drain_wind();
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    gusts_on = v;
  endtask

  // Present one tick, hold it until taken, then record the expected word.
  task automatic send_tick(logic [15:0] dt, bit known, wind_t want);
    wind_t w;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    time_step_i <= dt;
    do @(posedge clk_i); while (in_stall_o);
    w = advance_wind(longint'(dt));
    wind_q.push_back(known ? want : w);
  endtask

  // Mostly frame-sized steps, with full-range values and the extremes mixed in.
  function automatic logic [15:0] pick_step();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 16'($urandom_range(4000));
    if (r < 85) return 16'($urandom_range(65535));
    if (r < 92) return 16'hFFFF;
    if (r < 96) return 16'd0;
    return 16'($urandom_range(40000, 65535));
  endfunction

  // Check every taken word against the oldest expectation; stall at random.
  always @(posedge clk_i) begin
    wind_t got, exp_w;
    out_stall_i <= ($urandom_range(99) < stall_pct);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {gust_level_o, offset_x_o, offset_y_o, offset_z_o};
      if (wind_q.size() == 0) begin
        $display("%0t: unexpected word level=%0d", $time, gust_level_o);
        errors++;
      end else begin
        exp_w = wind_q.pop_front();
        if (got.level !== exp_w.level) begin
          $display("%0t: gust_level expected %0d actual %0d", $time, exp_w.level, got.level);
          errors++;
        end
        if (got.ox !== exp_w.ox) begin
          $display("%0t: offset_x expected %0d actual %0d", $time,
                   $signed(exp_w.ox), $signed(got.ox));
          errors++;
        end
        if (got.oy !== exp_w.oy) begin
          $display("%0t: offset_y expected %0d actual %0d", $time,
                   $signed(exp_w.oy), $signed(got.oy));
          errors++;
        end
        if (got.oz !== exp_w.oz) begin
          $display("%0t: offset_z expected %0d actual %0d", $time,
                   $signed(exp_w.oz), $signed(got.oz));
          errors++;
        end
      end
    end
  end

  // Watchdog: any handshake resets the count of quiet cycles.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL random_gust_and_direction_generator");
      $finish;
    end
  end

  initial begin
    tick_row_t rows[$];
    wind_t still;
    wind_t none;
    int seg_items[5] = '{400, 60, 400, 60, 330};
    bit seg_en[5] = '{1, 0, 1, 0, 1};
    int seg_phase[5] = '{0, 0, 1, 2, 2};

    errors = 0;
    quiet_cycles = 0;
    gap_pct = 0;
    stall_pct = 0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_wdata_i = 1'b0;
    in_valid_i = 1'b0;
    time_step_i = '0;
    out_stall_i = 1'b0;
    reset_wind();

    // With gusts off straight after reset the level is pinned to full and
    // the offset has never moved.
    still = '{level: (QB+1)'(ONE), ox: '0, oy: '0, oz: '0};
    none = '0;
    rows = '{
      '{0, 16'h0000, 1, still}, '{0, 16'hFFFF, 1, still},
      '{0, 16'h5555, 1, still}, '{0, 16'hAAAA, 1, still},
      '{1, 16'h0000, 0, none},  '{1, 16'h0001, 0, none},
      '{1, 16'h0000, 0, none},  '{1, 16'hFFFF, 0, none},
      '{1, 16'h0010, 0, none},  '{1, 16'hFFFF, 0, none},
      '{1, 16'h8000, 0, none},  '{1, 16'h7FFF, 0, none},
      '{1, 16'h0444, 0, none},  '{1, 16'hFFFF, 0, none},
      '{1, 16'hFFFF, 0, none},  '{1, 16'h0001, 0, none},
      '{1, 16'h5555, 0, none},  '{1, 16'hAAAA, 0, none},
      '{0, 16'h1234, 0, none},  '{0, 16'hFFFF, 0, none},
      '{1, 16'h0000, 0, none},  '{1, 16'hFFFF, 0, none}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table; write the enable on the first row and when a row changes it.
    foreach (rows[i]) begin
      if (rows[i].en != gusts_on || i == 0) begin
        in_valid_i <= 1'b0;
        write_enable(rows[i].en);
      end
      send_tick(rows[i].dt, rows[i].known, rows[i].want);
    end

    // Random segments: receiver-heavy stalling, then sender-heavy idling, then neither.
    for (int s = 0; s < 5; s++) begin
      in_valid_i <= 1'b0;
      write_enable(seg_en[s]);
      case (seg_phase[s])
        0: begin gap_pct = 19; stall_pct = 74; end
        1: begin gap_pct = 74; stall_pct = 19; end
        default: begin gap_pct = 0; stall_pct = 0; end
      endcase
      for (int k = 0; k < seg_items[s]; k++) send_tick(pick_step(), 0, none);
    end
    in_valid_i <= 1'b0;
    drain_wind();

    if (errors == 0)
      $display("PASS random_gust_and_direction_generator");
    else
      $display("FAIL random_gust_and_direction_generator");
    $finish;
  end

endmodule
